### rtl/gmps_pkg.sv
package gmps_pkg;

	localparam int CELL_W = 16;
	localparam int OUT_W = 24;
	localparam int CFG_W = 9;
	localparam int CFG_IDX_W = 4;
	localparam int ROW_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 4'd1;

	localparam logic [CFG_W-1:0] MAX_ROWS = 9'd256;
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	// Position of a cell within its grid, worked out when the beat is taken.
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic has_right;
		logic last_col;
		logic last_grid;
	} gmps_tag_t;

	localparam int TAG_W = $bits(gmps_tag_t);

endpackage

### rtl/grid_max_path_sum.sv
// Best downward path sum over a grid whose cells arrive in row-major order, one beat per
// cell. Cells can be sent on every cycle while the queue has room, bounded by the
// single read port of the row store, which fetches one entry of the previous row per cell.
// A two-entry queue separates beat acceptance from the datapath, and the grid maximum
// appears on best_sum in the cycle after the last cell of a grid leaves that queue; a held
// result stalls only the last cell of the following grid. Writing num_rows or num_cols
// abandons any grid in progress, and must happen only while the block is idle.
module grid_max_path_sum #(
	parameter int MAX_COLS = 256,
	parameter int SUM_WIDTH = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_en,
	input  logic [gmps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gmps_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               cell_valid,
	output logic                               cell_ready,
	input  logic [gmps_pkg::CELL_W-1:0]        cell_value,
	output logic                               best_sum_valid,
	input  logic                               best_sum_ready,
	output logic [gmps_pkg::OUT_W-1:0]         best_sum
);
	import gmps_pkg::*;

	localparam int CW = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
	localparam int DATA_W = TAG_W + CW + CELL_W;

	logic              push;
	gmps_tag_t         push_tag;
	logic [CW-1:0]     push_col;
	logic [CELL_W-1:0] push_cell;
	logic              restart;
	logic              queue_ready;
	logic              pop;
	logic              pop_valid;
	logic [DATA_W-1:0] pop_data;
	gmps_tag_t         item_tag;
	logic [CW-1:0]     item_col;
	logic [CELL_W-1:0] item_cell;

	assign cell_ready = queue_ready;

	gmps_front #(
		.MAX_COLS(MAX_COLS),
		.CW(CW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_en(cfg_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cell_valid(cell_valid),
		.cell_value(cell_value),
		.push_ready(queue_ready),
		.push(push),
		.push_tag(push_tag),
		.push_col(push_col),
		.push_cell(push_cell),
		.restart(restart)
	);

	gmps_queue #(
		.DATA_W(DATA_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_tag, push_col, push_cell}),
		.push_ready(queue_ready),
		.pop(pop),
		.pop_valid(pop_valid),
		.pop_data(pop_data)
	);

	assign {item_tag, item_col, item_cell} = pop_data;

	gmps_back #(
		.MAX_COLS(MAX_COLS),
		.SUM_WIDTH(SUM_WIDTH),
		.CW(CW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.restart(restart),
		.item_valid(pop_valid),
		.item_tag(item_tag),
		.item_col(item_col),
		.item_cell(item_cell),
		.item_take(pop),
		.best_sum_valid(best_sum_valid),
		.best_sum_ready(best_sum_ready),
		.best_sum(best_sum)
	);

endmodule

### rtl/gmps_front.sv
module gmps_front #(
	parameter int MAX_COLS = 256,
	parameter int CW = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_en,
	input  logic [gmps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gmps_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               cell_valid,
	input  logic [gmps_pkg::CELL_W-1:0]        cell_value,
	input  logic                               push_ready,
	output logic                               push,
	output gmps_pkg::gmps_tag_t                push_tag,
	output logic [CW-1:0]                      push_col,
	output logic [gmps_pkg::CELL_W-1:0]        push_cell,
	output logic                               restart
);
	import gmps_pkg::*;

	localparam int XW = (CW > CFG_W ? CW : CFG_W) + 1;
	localparam logic [XW-1:0] MAX_COLS_X = XW'(MAX_COLS);

	logic [CFG_W-1:0] num_rows_q;
	logic [CFG_W-1:0] num_cols_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CFG_W-1:0] eff_rows;
	logic [XW-1:0]    eff_cols;
	logic [XW-1:0]    col_next;
	logic [CFG_W-1:0] row_next;
	logic             last_col;
	logic             last_row;

	always_comb begin
		if (num_rows_q == '0) begin
			eff_rows = CFG_W'(1);
		end else if (num_rows_q > MAX_ROWS) begin
			eff_rows = MAX_ROWS;
		end else begin
			eff_rows = num_rows_q;
		end
		if (num_cols_q == '0) begin
			eff_cols = XW'(1);
		end else if (XW'(num_cols_q) > MAX_COLS_X) begin
			eff_cols = MAX_COLS_X;
		end else begin
			eff_cols = XW'(num_cols_q);
		end
	end

	assign col_next = XW'(col_q) + XW'(1);
	assign row_next = CFG_W'(row_q) + CFG_W'(1);
	assign last_col = (col_next == eff_cols);
	assign last_row = (row_next == eff_rows);

	assign restart = cfg_en && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS);
	assign push = cell_valid && push_ready;

	always_comb begin
		push_tag.first_row = (row_q == '0);
		push_tag.first_col = (col_q == '0);
		push_tag.has_right = !last_col;
		push_tag.last_col = last_col;
		push_tag.last_grid = last_col && last_row;
	end
	assign push_col = col_q;
	assign push_cell = cell_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= CFG_W'(1);
			num_cols_q <= CFG_W'(1);
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			if (cfg_index == REG_NUM_ROWS) begin
				num_rows_q <= cfg_data;
			end else begin
				num_cols_q <= cfg_data;
			end
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_next[ROW_W-1:0];
			end else begin
				col_q <= col_next[CW-1:0];
			end
		end
	end

endmodule

### rtl/gmps_queue.sv
module gmps_queue #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              push_ready,
	input  logic              pop,
	output logic              pop_valid,
	output logic [DATA_W-1:0] pop_data
);
	logic [DATA_W-1:0] slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### rtl/gmps_back.sv
module gmps_back #(
	parameter int MAX_COLS = 256,
	parameter int SUM_WIDTH = 24,
	parameter int CW = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               restart,
	input  logic                               item_valid,
	input  gmps_pkg::gmps_tag_t                item_tag,
	input  logic [CW-1:0]                      item_col,
	input  logic [gmps_pkg::CELL_W-1:0]        item_cell,
	output logic                               item_take,
	output logic                               best_sum_valid,
	input  logic                               best_sum_ready,
	output logic [gmps_pkg::OUT_W-1:0]         best_sum
);
	import gmps_pkg::*;

	localparam int AW = (SUM_WIDTH > CELL_W ? SUM_WIDTH : CELL_W) + 1;
	localparam int OW = SUM_WIDTH > OUT_W ? SUM_WIDTH : OUT_W;
	localparam logic [AW-1:0] SUM_MAX_X = AW'({SUM_WIDTH{1'b1}});
	localparam logic [OW-1:0] OUT_MAX_X = OW'(OUT_MAX);

	logic [SUM_WIDTH-1:0] row_mem [MAX_COLS];
	logic [SUM_WIDTH-1:0] rd_q;
	logic                 fwd_q;
	logic [SUM_WIDTH-1:0] fwd_data_q;
	logic [SUM_WIDTH-1:0] up_q;
	logic [SUM_WIDTH-1:0] left_q;
	logic [SUM_WIDTH-1:0] first_sum_q;
	logic [SUM_WIDTH-1:0] running_max_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	logic [SUM_WIDTH-1:0] above_right;
	logic [SUM_WIDTH-1:0] right_val;
	logic [SUM_WIDTH-1:0] best_lu;
	logic [SUM_WIDTH-1:0] best;
	logic [AW-1:0]        sum_wide;
	logic [SUM_WIDTH-1:0] sum;
	logic [SUM_WIDTH-1:0] max_next;
	logic [OW-1:0]        max_ext;
	logic [CW-1:0]        rd_addr;
	logic                 slot_free;

	assign above_right = fwd_q ? fwd_data_q : rd_q;
	assign right_val = item_tag.has_right ? above_right : '0;

	always_comb begin
		best_lu = (up_q > left_q) ? up_q : left_q;
		if (item_tag.first_row) begin
			best = '0;
		end else begin
			best = (right_val > best_lu) ? right_val : best_lu;
		end
		sum_wide = AW'(item_cell) + AW'(best);
		sum = (sum_wide > SUM_MAX_X) ? {SUM_WIDTH{1'b1}} : sum_wide[SUM_WIDTH-1:0];
		max_next = (sum > running_max_q) ? sum : running_max_q;
		max_ext = OW'(max_next);
		// The next cell needs the entry to the right of its own column.
		rd_addr = item_tag.last_col ? CW'(1) : item_col + CW'(2);
	end

	assign slot_free = !out_valid_q || best_sum_ready;
	assign item_take = item_valid && !restart && (!item_tag.last_grid || slot_free);

	always_ff @(posedge clk) begin
		if (item_take) begin
			row_mem[item_col] <= sum;
			rd_q <= row_mem[rd_addr];
			fwd_data_q <= sum;
			if (item_tag.last_col) begin
				up_q <= item_tag.first_col ? sum : first_sum_q;
			end else begin
				up_q <= above_right;
			end
			if (item_tag.first_col) begin
				first_sum_q <= sum;
			end
		end
		if (item_take && item_tag.last_grid) begin
			out_data_q <= (max_ext > OUT_MAX_X) ? OUT_MAX : max_ext[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
			left_q <= '0;
			running_max_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (restart) begin
				left_q <= '0;
				running_max_q <= '0;
			end else if (item_take) begin
				fwd_q <= (rd_addr == item_col);
				left_q <= item_tag.last_col ? '0 : up_q;
				running_max_q <= item_tag.last_grid ? '0 : max_next;
			end
			if (item_take && item_tag.last_grid) begin
				out_valid_q <= 1'b1;
			end else if (best_sum_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign best_sum_valid = out_valid_q;
	assign best_sum = out_data_q;

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		item_take && item_tag.last_grid |-> !out_valid_q || best_sum_ready)
		else $error("grid result taken while the previous one is still pending");

	a_max_cleared_after_grid: assert property (@(posedge clk) disable iff (!arst_n)
		item_take && item_tag.last_grid |=> running_max_q == '0)
		else $error("running maximum not cleared after the last cell of a grid");

	a_left_cleared_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		item_take && item_tag.last_col |=> left_q == '0)
		else $error("left neighbor not cleared at the end of a row");

	a_result_follows_last_cell: assert property (@(posedge clk) disable iff (!arst_n)
		item_take && item_tag.last_grid |=> best_sum_valid)
		else $error("no result after the last cell of a grid");

endmodule
